>>> hdl/i2c_master_bit_engine_defines.svh
// assertion macros for the i2c master bit engine

`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent holds, consequent holds in the next cycle
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   localparam int CLEAR_PULSES = 9;
   localparam int BYTE_BITS    = 8;

   // command codes as carried in req_type
   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_SEND  = 3'd3,
      CMD_RECV  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6,
      CMD_CLEAR = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_data_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_received;
      logic [7:0] rx_byte;
      logic       bus_released;
      logic       rejected;
   } rsp_data_type;

   // engine state carried from one request to the next
   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] step;
      logic [7:0] shift;
      logic       scl;
      logic       sda;
      logic       ack;
      logic [7:0] rx;
      logic [3:0] pulse;
      logic       clear_ok;
   } state_type;

   localparam state_type STATE_RESET = '{
      cmd:      CMD_IDLE,
      step:     5'd0,
      shift:    8'd0,
      scl:      1'b1,
      sda:      1'b1,
      ack:      1'b0,
      rx:       8'd0,
      pulse:    4'd0,
      clear_ok: 1'b0
   };

endpackage

`default_nettype wire

>>> hdl/i2cm_step.sv
`default_nettype none

// next-state and result logic for one half-period tick
module i2cm_step import i2cm_pkg::*; (
   input  state_type    state,
   input  req_data_type req,
   output state_type    state_next,
   output rsp_data_type rsp
);

   localparam logic [4:0] BYTE_STEPS = 5'(2 * BYTE_BITS);
   localparam logic [3:0] PULSE_MAX  = 4'(CLEAR_PULSES);

   state_type  nx;
   cmd_type    req_cmd;
   logic [4:0] s;
   logic [3:0] pulse_inc;
   logic [7:0] rx_shift;
   logic       fin;
   logic       rej;

   always_comb begin
      nx        = state;
      req_cmd   = cmd_type'(req.req_type);
      s         = state.step + 5'd1;
      pulse_inc = state.pulse + 4'd1;
      rx_shift  = {state.shift[6:0], req.sda_in};
      fin       = 1'b0;
      rej       = 1'b0;

      if (state.cmd != CMD_IDLE) begin
         rej     = (req_cmd != CMD_IDLE);
         nx.step = s;
         case (state.cmd)
            CMD_START: begin
               if (s == 5'd1) begin
                  nx.sda = 1'b0;
               end else begin
                  nx.scl = 1'b0;
                  fin    = 1'b1;
               end
            end
            CMD_STOP: begin
               if (s == 5'd1) begin
                  nx.scl = 1'b1;
               end else begin
                  nx.sda = 1'b1;
                  fin    = 1'b1;
               end
            end
            CMD_SEND: begin
               if (s[0]) begin
                  nx.scl = 1'b1;
               end else begin
                  nx.scl = 1'b0;
                  if (s < BYTE_STEPS) begin
                     nx.sda   = state.shift[7];
                     nx.shift = {state.shift[6:0], 1'b0};
                  end else if (s == BYTE_STEPS) begin
                     nx.sda = 1'b1;   // release sda for the ack slot
                  end else begin
                     nx.ack = ~req.sda_in;
                     nx.sda = 1'b0;
                     fin    = 1'b1;
                  end
               end
            end
            CMD_RECV: begin
               if (s[0]) begin
                  nx.scl = 1'b1;
               end else begin
                  nx.shift = rx_shift;
                  nx.scl   = 1'b0;
                  if (s >= BYTE_STEPS) begin
                     nx.rx = rx_shift;
                     fin   = 1'b1;
                  end
               end
            end
            CMD_ACK, CMD_NACK: begin
               if (s == 5'd1) begin
                  nx.scl = 1'b1;
               end else begin
                  nx.scl = 1'b0;
                  fin    = 1'b1;
               end
            end
            default: begin
               // bus clear
               if (s[0]) begin
                  if (req.sda_in) begin
                     nx.clear_ok = 1'b1;
                     fin         = 1'b1;
                  end else begin
                     nx.scl = 1'b0;
                  end
               end else begin
                  nx.scl   = 1'b1;
                  nx.pulse = pulse_inc;
                  fin      = (pulse_inc >= PULSE_MAX);
               end
            end
         endcase
         if (fin) begin
            nx.cmd = CMD_IDLE;
         end
      end else if (req_cmd != CMD_IDLE) begin
         nx.cmd  = req_cmd;
         nx.step = 5'd0;
         case (req_cmd)
            CMD_START: begin
               nx.scl = 1'b1;
               nx.sda = 1'b1;
            end
            CMD_STOP: begin
               nx.sda = 1'b0;
            end
            CMD_SEND: begin
               nx.sda   = req.tx_byte[7];
               nx.shift = {req.tx_byte[6:0], 1'b0};
            end
            CMD_RECV: begin
               nx.sda   = 1'b1;
               nx.shift = 8'd0;
            end
            CMD_ACK: begin
               nx.sda = 1'b0;
            end
            CMD_NACK: begin
               nx.sda = 1'b1;
            end
            default: begin
               nx.pulse    = 4'd0;
               nx.clear_ok = 1'b0;
            end
         endcase
      end
   end

   assign state_next       = nx;
   assign rsp.scl_out      = nx.scl;
   assign rsp.sda_out      = nx.sda;
   assign rsp.busy_res     = (nx.cmd != CMD_IDLE);
   assign rsp.done_res     = fin;
   assign rsp.ack_received = nx.ack;
   assign rsp.rx_byte      = nx.rx;
   assign rsp.bus_released = nx.clear_ok;
   assign rsp.rejected     = rej;

endmodule

`default_nettype wire

>>> hdl/i2c_master_bit_engine.sv
// I2C master pin engine. Every request is one half SCL period: while idle a
// nonzero req_type starts start, stop, send, receive, ack, nack or bus clear,
// and each later request advances the running command by one half period,
// sampling sda_in where the command reads the bus. Every request yields
// exactly one response with the SCL/SDA levels to drive (1 = released), busy
// and done, the ack of the last send, the last received byte, the bus clear
// outcome and a flag for a command that arrived while busy and was dropped.
// Rate: one request per clock while rsp_stall is low. A request is held in the
// input register, then the engine state and the response are computed and land
// in the response register, which drives rsp_valid. The loop that bounds
// throughput is the state update through i2cm_step; a stalled response
// register stalls the input register and then req_stall.

`default_nettype none

`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine import i2cm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_data_type      rsp_data
);

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_data_type in_data_ff;

   // engine state
   state_type    state_ff;
   state_type    state_in;

   // response register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type out_data_in;

   logic         advance;
   logic         req_take;

   // the response register frees up when empty or when being taken
   assign advance   = ~out_valid_ff | ~rsp_stall;
   // the input register can load when empty or when it moves on this cycle
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   i2cm_step u_step (
      .state      (state_ff),
      .req        (in_data_ff),
      .state_next (state_in),
      .rsp        (out_data_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // the state moves only when a request passes into the response register
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a completing tick never reports busy
   `I2CM_ASSERT_SAME(a_done_not_busy, clock, reset,
      out_valid_ff && out_data_ff.done_res, !out_data_ff.busy_res)
   // a dropped command only happens while a command was running
   `I2CM_ASSERT_SAME(a_reject_when_busy, clock, reset,
      out_valid_ff && out_data_ff.rejected,
      out_data_ff.busy_res || out_data_ff.done_res)
   // an accepted request always lands in the input register
   `I2CM_ASSERT_NEXT(a_take_lands, clock, reset, req_take, in_valid_ff)
   // a request leaving the input register always lands in the response register
   `I2CM_ASSERT_NEXT(a_pass_lands, clock, reset, in_valid_ff && advance, out_valid_ff)

endmodule

`default_nettype wire
